@@ rtl/core/twpw_pkg.sv @@
`default_nettype none
package twpw_pkg;

  localparam int DEF_FRAC_BITS     = 16;
  localparam int DEF_CORDIC_STAGES = 24;

  // fixed datapath widths
  localparam int XYW  = 34;  // CORDIC x/y, Q.29 plus headroom
  localparam int SW   = 68;  // squared distance, padded to whole bit pairs
  localparam int RTW  = 34;  // integer square root
  localparam int SRW  = 38;  // square root partial remainder
  localparam int NW   = 65;  // |twist| * |distance - radius|
  localparam int RADW = 31;

  localparam logic [63:0]            PI_Q48   = 64'h3243F6A8885A3;
  localparam logic signed [XYW-1:0]  GAIN_Q29 = 34'sd326016437;

  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_CIRCLE_RAD   = 3'd2,
    CFG_TWIST_ANGLE  = 3'd3,
    CFG_WARP_INSIDE  = 3'd4,
    CFG_WARP_OUTSIDE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               reverse_dir;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               was_warped;
  } out_t;

  // per-item data riding alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               rev;
    logic               warp;
    logic               neg;
    logic               flip;
  } side_t;

  // round(pi * 2^48 / 2^sh)
  function automatic logic [63:0] pi_round(input int sh);
    return (PI_Q48 + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // atan(2^-i) in Q.frac, via the Taylor series on Q48
  function automatic logic [63:0] atan_q(input int i, input int frac);
    logic [63:0] acc;
    logic [63:0] term;
    int          s;
    acc = 64'd0;
    if (i == 0) begin
      acc = PI_Q48 >> 2;
    end else begin
      for (int k = 0; k < 64; k++) begin
        s = 48 - i * (2 * k + 1);
        if (s >= 0) begin
          term = (64'd1 << s) / 64'(2 * k + 1);
          acc  = k[0] ? acc - term : acc + term;
        end
      end
    end
    return (acc + (64'd1 << (47 - frac))) >> (48 - frac);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/twpw_sqrt_cell.sv @@
`default_nettype none
// one result bit of a restoring integer square root
module twpw_sqrt_cell import twpw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire side_t            side_i,
  input  wire logic [SW-1:0]    s_i,
  input  wire logic [RTW-1:0]   root_i,
  input  wire logic [SRW-1:0]   rem_i,
  output logic                  valid_o,
  output side_t                 side_o,
  output logic [SW-1:0]         s_o,
  output logic [RTW-1:0]        root_o,
  output logic [SRW-1:0]        rem_o
);

  logic [SRW-1:0] sh, trial;
  logic           ge;

  always_comb begin
    sh    = {rem_i[SRW-3:0], s_i[SW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    ge    = (sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      s_o    <= s_i << 2;
      root_o <= {root_i[RTW-2:0], ge};
      rem_o  <= ge ? sh - trial : sh;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/twpw_div_cell.sv @@
`default_nettype none
// one quotient bit of N / radius, folded straight into quotient mod 2*pi
module twpw_div_cell import twpw_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [RADW-1:0]       rad_i,
  input  wire logic                  valid_i,
  input  wire side_t                 side_i,
  input  wire logic [NW-1:0]         n_i,
  input  wire logic [RADW-1:0]       rem_i,
  input  wire logic [FRAC_BITS+2:0]  m_i,
  output logic                       valid_o,
  output side_t                      side_o,
  output logic [NW-1:0]              n_o,
  output logic [RADW-1:0]            rem_o,
  output logic [FRAC_BITS+2:0]       m_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam logic [TW-1:0] TWO_PI = TW'(pi_round(47 - FRAC_BITS));

  logic [RADW:0] r2;
  logic          ge;
  logic [TW:0]   t;

  always_comb begin
    r2 = {rem_i, n_i[NW-1]};
    ge = (r2 >= {1'b0, rad_i});
    t  = {m_i, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      n_o    <= n_i << 1;
      rem_o  <= ge ? RADW'(r2 - {1'b0, rad_i}) : RADW'(r2);
      m_o    <= (t >= {1'b0, TWO_PI}) ? TW'(t - {1'b0, TWO_PI}) : TW'(t);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/twpw_cordic_cell.sv @@
`default_nettype none
// one rotation-mode CORDIC micro-rotation
module twpw_cordic_cell import twpw_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int STAGE     = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire side_t                       side_i,
  input  wire logic signed [XYW-1:0]       x_i,
  input  wire logic signed [XYW-1:0]       y_i,
  input  wire logic signed [FRAC_BITS+3:0] a_i,
  output logic                             valid_o,
  output side_t                            side_o,
  output logic signed [XYW-1:0]            x_o,
  output logic signed [XYW-1:0]            y_o,
  output logic signed [FRAC_BITS+3:0]      a_o
);

  localparam int AW = FRAC_BITS + 4;
  localparam logic signed [AW-1:0] ATAN = $signed(AW'(atan_q(STAGE, FRAC_BITS)));

  logic signed [XYW-1:0] xs, ys;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      if (!a_i[AW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        a_o <= a_i - ATAN;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        a_o <= a_i + ATAN;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/twirl_point_warp_core.sv @@
`default_nettype none
// Twirl point warp: each item is a Q15.16 point plus a reverse flag. The
// block measures its distance from the configured center and, inside the
// enabled zone, rotates it about the center by twist * (distance - radius) /
// radius radians; other points pass through with was_warped low. One item is
// accepted per cycle while the input is not stalled. Each item passes through
// 34 square-root cells, 65 divider cells (one quotient bit each, reduced
// modulo 2*pi on the fly) and the CORDIC cells, placed among registered
// multiply and add stages.
// The output has a skid register; the input stalls only once that fills.
// Configure only while no item is in flight.
module twirl_point_warp_core import twpw_pkg::*; #(
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam int AW = FRAC_BITS + 4;
  localparam logic [TW-1:0]        TWO_PI = TW'(pi_round(47 - FRAC_BITS));
  localparam logic signed [AW-1:0] PI_F   = $signed(AW'(pi_round(48 - FRAC_BITS)));
  localparam logic signed [AW-1:0] HPI_F  = $signed(AW'(pi_round(49 - FRAC_BITS)));

  // ---------------- configuration ----------------
  logic signed [31:0] cx_q, cy_q, twist_q;
  logic [RADW-1:0]    rad_q, rad_eff;
  logic               win_q, wout_q;
  logic [2*RADW-1:0]  r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      rad_q   <= RADW'(1) << FRAC_BITS;
      twist_q <= '0;
      win_q   <= 1'b1;
      wout_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:     cx_q    <= cfg_wdata_i;
        CFG_CENTER_Y:     cy_q    <= cfg_wdata_i;
        CFG_CIRCLE_RAD:   rad_q   <= cfg_wdata_i[RADW-1:0];
        CFG_TWIST_ANGLE:  twist_q <= cfg_wdata_i;
        CFG_WARP_INSIDE:  win_q   <= cfg_wdata_i[0];
        CFG_WARP_OUTSIDE: wout_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // zero radius behaves as the smallest legal one
  assign rad_eff = (rad_q == '0) ? RADW'(1) : rad_q;

  // radius squared follows the config register; settled long before use
  always_ff @(posedge clk_i) begin
    r2_q <= rad_eff * rad_eff;
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------- A: offsets from center ----------------
  logic  va_q;
  side_t sa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q.pos_x <= in_data_i.pos_x;
      sa_q.pos_y <= in_data_i.pos_y;
      sa_q.dx    <= $signed({in_data_i.pos_x[31], in_data_i.pos_x}) - $signed({cx_q[31], cx_q});
      sa_q.dy    <= $signed({in_data_i.pos_y[31], in_data_i.pos_y}) - $signed({cy_q[31], cy_q});
      sa_q.rev   <= in_data_i.reverse_dir;
      sa_q.warp  <= 1'b0;
      sa_q.neg   <= 1'b0;
      sa_q.flip  <= 1'b0;
    end
  end

  // ---------------- B..E: squared distance ----------------
  logic        vb_q, vc_q, vd_q, ve_q;
  side_t       sb_q, sc_q, sd_q, se_q;
  logic [32:0] adx_q, ady_q;
  logic [33:0] pllx_q, plly_q;
  logic [32:0] phlx_q, phly_q;
  logic [31:0] phhx_q, phhy_q;
  logic [65:0] sqx_q, sqy_q, ssum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q   <= sa_q;
      adx_q  <= sa_q.dx[32] ? 33'(-sa_q.dx) : 33'(sa_q.dx);
      ady_q  <= sa_q.dy[32] ? 33'(-sa_q.dy) : 33'(sa_q.dy);
      // square split into 16/17-bit halves
      sc_q   <= sb_q;
      pllx_q <= adx_q[16:0] * adx_q[16:0];
      plly_q <= ady_q[16:0] * ady_q[16:0];
      phlx_q <= adx_q[32:17] * adx_q[16:0];
      phly_q <= ady_q[32:17] * ady_q[16:0];
      phhx_q <= adx_q[32:17] * adx_q[32:17];
      phhy_q <= ady_q[32:17] * ady_q[32:17];
      sd_q   <= sc_q;
      sqx_q  <= (66'(phhx_q) << 34) + (66'(phlx_q) << 18) + 66'(pllx_q);
      sqy_q  <= (66'(phhy_q) << 34) + (66'(phly_q) << 18) + 66'(plly_q);
      se_q   <= sd_q;
      ssum_q <= sqx_q + sqy_q;
    end
  end

  // ---------------- F: zone test ----------------
  logic          vf_q;
  side_t         sf_q, sf_d;
  logic [SW-1:0] s_f_q;
  logic          in_circ, out_circ;

  always_comb begin
    in_circ   = (ssum_q < 66'(r2_q));
    out_circ  = (ssum_q > 66'(r2_q));
    sf_d      = se_q;
    sf_d.warp = (win_q | out_circ) & (wout_q | in_circ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q  <= sf_d;
      s_f_q <= SW'(ssum_q);
    end
  end

  // ---------------- square root chain ----------------
  logic           sq_v    [RTW+1];
  side_t          sq_side [RTW+1];
  logic [SW-1:0]  sq_s    [RTW+1];
  logic [RTW-1:0] sq_root [RTW+1];
  logic [SRW-1:0] sq_rem  [RTW+1];

  assign sq_v[0]    = vf_q;
  assign sq_side[0] = sf_q;
  assign sq_s[0]    = s_f_q;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    twpw_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .side_i  (sq_side[k]),
      .s_i     (sq_s[k]),
      .root_i  (sq_root[k]),
      .rem_i   (sq_rem[k]),
      .valid_o (sq_v[k+1]),
      .side_o  (sq_side[k+1]),
      .s_o     (sq_s[k+1]),
      .root_o  (sq_root[k+1]),
      .rem_o   (sq_rem[k+1])
    );
  end

  // ---------------- G..J: twist * (distance - radius) ----------------
  logic               vg_q, vh_q, vi_q, vj_q;
  side_t              sg_q, sh_q, si_q, sj_q;
  side_t              sh_d;
  logic signed [34:0] d_q;
  logic [33:0]        md_q;
  logic [31:0]        mt_q;
  logic [48:0]        pl_q, ph_q;
  logic [NW-1:0]      n_q;
  logic [65:0]        nsum;

  assign nsum = (66'(ph_q) << 17) + 66'(pl_q);

  always_comb begin
    sh_d     = sg_q;
    sh_d.neg = (twist_q[31] != d_q[34]) != sg_q.rev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else if (en) begin
      vg_q <= sq_v[RTW];
      vh_q <= vg_q;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sg_q    <= sq_side[RTW];
      d_q     <= $signed({1'b0, sq_root[RTW]}) - $signed({4'b0, rad_eff});
      sh_q    <= sh_d;
      md_q    <= d_q[34] ? 34'(-d_q) : 34'(d_q);
      mt_q    <= twist_q[31] ? 32'(-twist_q) : 32'(twist_q);
      si_q    <= sh_q;
      pl_q    <= mt_q * md_q[16:0];
      ph_q    <= mt_q * md_q[33:17];
      sj_q    <= si_q;
      n_q     <= nsum[NW-1:0];
    end
  end

  // ---------------- divider chain, angle mod 2*pi ----------------
  logic            dv_v    [NW+1];
  side_t           dv_side [NW+1];
  logic [NW-1:0]   dv_n    [NW+1];
  logic [RADW-1:0] dv_rem  [NW+1];
  logic [TW-1:0]   dv_m    [NW+1];

  assign dv_v[0]    = vj_q;
  assign dv_side[0] = sj_q;
  assign dv_n[0]    = n_q;
  assign dv_rem[0]  = '0;
  assign dv_m[0]    = '0;

  for (genvar k = 0; k < NW; k++) begin : g_div
    twpw_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .rad_i   (rad_eff),
      .valid_i (dv_v[k]),
      .side_i  (dv_side[k]),
      .n_i     (dv_n[k]),
      .rem_i   (dv_rem[k]),
      .m_i     (dv_m[k]),
      .valid_o (dv_v[k+1]),
      .side_o  (dv_side[k+1]),
      .n_o     (dv_n[k+1]),
      .rem_o   (dv_rem[k+1]),
      .m_o     (dv_m[k+1])
    );
  end

  // ---------------- K..M: angle into [-pi/2, pi/2] ----------------
  logic               vk_q, vl_q, vm_q;
  side_t              sk_q, sl_q, sm_q;
  side_t              sm_d;
  logic [TW-1:0]      a0_q;
  logic signed [AW-1:0] a1_q, a2_q, a2_d;

  always_comb begin
    sm_d = sl_q;
    if (a1_q > HPI_F) begin
      a2_d      = a1_q - PI_F;
      sm_d.flip = 1'b1;
    end else if (a1_q < -HPI_F) begin
      a2_d      = a1_q + PI_F;
      sm_d.flip = 1'b1;
    end else begin
      a2_d      = a1_q;
      sm_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      vk_q <= dv_v[NW];
      vl_q <= vk_q;
      vm_q <= vl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sk_q <= dv_side[NW];
      a0_q <= (dv_side[NW].neg && dv_m[NW] != '0) ? TWO_PI - dv_m[NW] : dv_m[NW];
      sl_q <= sk_q;
      // above pi wraps to the negative half turn
      if ({a0_q, 1'b0} > {1'b0, TWO_PI}) begin
        a1_q <= $signed({1'b0, a0_q}) - $signed({1'b0, TWO_PI});
      end else begin
        a1_q <= $signed({1'b0, a0_q});
      end
      sm_q <= sm_d;
      a2_q <= a2_d;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic                  cr_v    [CORDIC_STAGES+1];
  side_t                 cr_side [CORDIC_STAGES+1];
  logic signed [XYW-1:0] cr_x    [CORDIC_STAGES+1];
  logic signed [XYW-1:0] cr_y    [CORDIC_STAGES+1];
  logic signed [AW-1:0]  cr_a    [CORDIC_STAGES+1];

  assign cr_v[0]    = vm_q;
  assign cr_side[0] = sm_q;
  assign cr_x[0]    = GAIN_Q29;
  assign cr_y[0]    = '0;
  assign cr_a[0]    = a2_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    twpw_cordic_cell #(.FRAC_BITS(FRAC_BITS), .STAGE(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cr_v[k]),
      .side_i  (cr_side[k]),
      .x_i     (cr_x[k]),
      .y_i     (cr_y[k]),
      .a_i     (cr_a[k]),
      .valid_o (cr_v[k+1]),
      .side_o  (cr_side[k+1]),
      .x_o     (cr_x[k+1]),
      .y_o     (cr_y[k+1]),
      .a_o     (cr_a[k+1])
    );
  end

  // ---------------- N..S: rotate offsets, add center back ----------------
  logic                  vn_q, vo_q, vp_q, vq_q, vr_q, vs_q;
  side_t                 sn_q, so_q, sp_q, sq_q, sr_q;
  logic signed [XYW-1:0] cos_q, sin_q;
  logic signed [50:0]    p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q, p8_q;
  logic signed [51:0]    hx_q, lx_q, hy_q, ly_q;
  logic signed [67:0]    ox_q, oy_q;
  logic signed [38:0]    rx_q, ry_q;
  logic signed [39:0]    sumx, sumy;
  logic signed [31:0]    satx, saty;
  out_t                  os_q;

  always_comb begin
    sumx = 40'(rx_q) + 40'(cx_q);
    sumy = 40'(ry_q) + 40'(cy_q);
    if (sumx > 40'sd2147483647)       satx = 32'sh7FFFFFFF;
    else if (sumx < -40'sd2147483648) satx = 32'sh80000000;
    else                              satx = sumx[31:0];
    if (sumy > 40'sd2147483647)       saty = 32'sh7FFFFFFF;
    else if (sumy < -40'sd2147483648) saty = 32'sh80000000;
    else                              saty = sumy[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
      vo_q <= 1'b0;
      vp_q <= 1'b0;
      vq_q <= 1'b0;
      vr_q <= 1'b0;
      vs_q <= 1'b0;
    end else if (en) begin
      vn_q <= cr_v[CORDIC_STAGES];
      vo_q <= vn_q;
      vp_q <= vo_q;
      vq_q <= vp_q;
      vr_q <= vq_q;
      vs_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q  <= cr_side[CORDIC_STAGES];
      cos_q <= cr_side[CORDIC_STAGES].flip ? -cr_x[CORDIC_STAGES] : cr_x[CORDIC_STAGES];
      sin_q <= cr_side[CORDIC_STAGES].flip ? -cr_y[CORDIC_STAGES] : cr_y[CORDIC_STAGES];
      // offsets split at bit 16 to keep multipliers narrow
      so_q  <= sn_q;
      p1_q  <= cos_q * $signed(sn_q.dx[32:16]);
      p2_q  <= sin_q * $signed(sn_q.dy[32:16]);
      p3_q  <= cos_q * $signed({1'b0, sn_q.dx[15:0]});
      p4_q  <= sin_q * $signed({1'b0, sn_q.dy[15:0]});
      p5_q  <= sin_q * $signed(sn_q.dx[32:16]);
      p6_q  <= cos_q * $signed(sn_q.dy[32:16]);
      p7_q  <= sin_q * $signed({1'b0, sn_q.dx[15:0]});
      p8_q  <= cos_q * $signed({1'b0, sn_q.dy[15:0]});
      sp_q  <= so_q;
      hx_q  <= 52'(p1_q) - 52'(p2_q);
      lx_q  <= 52'(p3_q) - 52'(p4_q);
      hy_q  <= 52'(p5_q) + 52'(p6_q);
      ly_q  <= 52'(p7_q) + 52'(p8_q);
      sq_q  <= sp_q;
      ox_q  <= (68'(hx_q) <<< 16) + 68'(lx_q);
      oy_q  <= (68'(hy_q) <<< 16) + 68'(ly_q);
      sr_q  <= sq_q;
      rx_q  <= 39'((ox_q + 68'sd268435456) >>> 29);
      ry_q  <= 39'((oy_q + 68'sd268435456) >>> 29);
      os_q.out_x      <= sr_q.warp ? satx : sr_q.pos_x;
      os_q.out_y      <= sr_q.warp ? saty : sr_q.pos_y;
      os_q.was_warped <= sr_q.warp;
    end
  end

  // ---------------- output register and skid ----------------
  logic outv_q;
  out_t out_q, skid_q;
  logic taken;

  assign taken       = outv_q & !out_stall_i;
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q   <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (taken) begin
        skid_v_q <= 1'b0;
      end
    end else if (vs_q) begin
      if (!outv_q || taken) begin
        outv_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (taken) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (taken) begin
        out_q <= skid_q;
      end
    end else if (vs_q) begin
      if (!outv_q || taken) begin
        out_q <= os_q;
      end else begin
        skid_q <= os_q;
      end
    end
  end

endmodule
`default_nettype wire
